### rtl/plem_pkg.sv
// Shared types and constants for the polygon local extrema marker.
// Used by plem_ring_store and polygon_local_extrema_marker_top; no dependencies.
`default_nettype none
package plem_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 64;
  localparam int POINT_W      = 2 * COORD_W;
  localparam int IDX_W        = 6;
  localparam int NUM_W        = 16;
  localparam int IN_DATA_W    = 128;
  localparam int OUT_DATA_W   = 160;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_END,
    ST_INIT,
    ST_RD,
    ST_PROC,
    ST_LAST
  } state_t;

endpackage
`default_nettype wire

### rtl/plem_ring_store.sv
// Point store of one path: x in the low half, y in the high half of each entry.
// One write port, one read port with registered read data. Depends on plem_pkg.
`default_nettype none
module plem_ring_store #(
  parameter int DEPTH = plem_pkg::MAX_VERTICES,
  parameter int AW    = $clog2(plem_pkg::MAX_VERTICES)
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [plem_pkg::POINT_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output logic      [plem_pkg::POINT_W-1:0] rd_data
);

  logic [plem_pkg::POINT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/polygon_local_extrema_marker_top.sv
// Polygon local extrema marker: stores path points, then marks minima and maxima by y.
// Depends on plem_pkg and plem_ring_store.
// Points are taken one per cycle while loading; none are taken while the block scans or
// emits. After the last point of a path the block scans the stored ring, then emits one
// beat per vertex, each vertex read and then processed, the final beat needing no read;
// stalls on the output hold the block. The next path is taken after the final beat is loaded.
// rst clears the control state and the minima counter; the store needs no clearing.
`default_nettype none
module polygon_local_extrema_marker_top #(
  parameter int MAX_VERTICES = plem_pkg::MAX_VERTICES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // x [63:0], y [127:64]
  input  wire logic [plem_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // last_point
  input  wire logic                            s_axis_tlast,
  // path_is_open [0], path_kind [1]
  input  wire logic [1:0]                      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // vertex_index [5:0], out_x [69:6], out_y [133:70], is_local_min [134],
  // is_local_max [135], is_open_start [136], is_open_end [137],
  // minima_number [153:138], overflow [154], zeros above
  output logic      [plem_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // last_result
  output logic                                 m_axis_tlast,
  // kind_of_path on local-minimum beats, zero on all other beats
  output logic                                 m_axis_tuser
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int CWD = plem_pkg::COORD_W;

  plem_pkg::state_t state, state_next;

  logic [CW-1:0]  kept;
  logic           ovf;
  logic [15:0]    min_cnt;
  logic [CWD-1:0] last_x, last_y, x0, y0;
  logic           path_open, path_kind;
  logic [AW-1:0]  last_idx;
  logic [AW-1:0]  scan_k, idx;
  logic           scan_v, found;
  logic [CWD-1:0] first_y, diff_y;
  logic           noflag, up, up0;
  logic           pend_min, pend_max, pend_os;
  logic [CWD-1:0] cur_x, cur_y;

  logic [5:0]     o_idx;
  logic [CWD-1:0] o_x, o_y;
  logic           o_min, o_max, o_os, o_oe, o_kind, o_last, o_ovf, o_valid;
  logic [15:0]    o_num;

  logic [CWD-1:0] in_x, in_y, rd_x, rd_y;
  logic [plem_pkg::POINT_W-1:0] rd_data;
  logic           in_acc, is_dup, full, keep;
  logic [CW-1:0]  cnt_after;
  logic [CWD-1:0] lx, ly;
  logic           ring_drop;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           out_free;
  logic           lt_pc, lt_cc, step_max, step_min, end_min, end_max;
  logic           up_open, up_closed;

  assign in_x   = s_axis_tdata[CWD-1:0];
  assign in_y   = s_axis_tdata[2*CWD-1:CWD];
  assign rd_x   = rd_data[CWD-1:0];
  assign rd_y   = rd_data[2*CWD-1:CWD];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign is_dup = (kept != '0) && (in_x == last_x) && (in_y == last_y);
  assign full   = (kept == CW'(MAX_VERTICES));
  assign keep   = !is_dup && !full;
  assign cnt_after = kept + CW'(keep);
  assign lx = keep ? in_x : last_x;
  assign ly = keep ? in_y : last_y;
  // A closed path whose final point repeats the start loses that point.
  assign ring_drop = !s_axis_tuser[0] && (lx == x0) && (ly == y0);
  assign out_free = !o_valid || m_axis_tready;

  assign lt_pc = $signed(cur_y) < $signed(rd_y);
  assign lt_cc = $signed(rd_y) < $signed(cur_y);
  assign step_max = !noflag && lt_pc && up;
  assign step_min = !noflag && lt_cc && !up;
  assign end_min = path_open ? !up : (!noflag && (up != up0) && up0);
  assign end_max = path_open ? up  : (!noflag && (up != up0) && !up0);
  assign up_open   = !($signed(y0) < $signed(found ? first_y : y0));
  assign up_closed = $signed(y0) < $signed(diff_y);

  plem_ring_store #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc && keep),
    .wr_addr (kept[AW-1:0]),
    .wr_data ({in_y, in_x}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plem_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = scan_k;
    unique case (state)
      plem_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (in_acc && s_axis_tlast && (cnt_after >= CW'(2))) begin
          state_next = plem_pkg::ST_SCAN;
        end
      end
      plem_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_k == last_idx) begin
          state_next = plem_pkg::ST_SCAN_END;
        end
      end
      plem_pkg::ST_SCAN_END: state_next = plem_pkg::ST_INIT;
      plem_pkg::ST_INIT:     state_next = plem_pkg::ST_RD;
      plem_pkg::ST_RD: begin
        rd_en      = 1'b1;
        rd_addr    = idx;
        state_next = plem_pkg::ST_PROC;
      end
      plem_pkg::ST_PROC: begin
        if (out_free) begin
          state_next = (idx == last_idx) ? plem_pkg::ST_LAST : plem_pkg::ST_RD;
        end
      end
      plem_pkg::ST_LAST: begin
        if (out_free) begin
          state_next = plem_pkg::ST_LOAD;
        end
      end
      default: state_next = plem_pkg::ST_LOAD;
    endcase
  end

  // Path loading and bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= '0;
      ovf  <= 1'b0;
    end else if (state == plem_pkg::ST_LOAD && in_acc) begin
      if (s_axis_tlast) begin
        if (cnt_after < CW'(2)) begin
          kept <= '0;
          ovf  <= 1'b0;
        end else begin
          kept <= cnt_after;
          ovf  <= ovf || (!is_dup && full);
        end
      end else begin
        kept <= cnt_after;
        ovf  <= ovf || (!is_dup && full);
      end
    end else if (state == plem_pkg::ST_LAST && out_free) begin
      kept <= '0;
      ovf  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && keep) begin
      last_x <= in_x;
      last_y <= in_y;
      if (kept == '0) begin
        x0 <= in_x;
        y0 <= in_y;
      end
    end
    if (in_acc && s_axis_tlast) begin
      path_open <= s_axis_tuser[0];
      path_kind <= s_axis_tuser[1];
      last_idx  <= AW'(cnt_after - CW'(ring_drop) - CW'(1));
      noflag    <= !s_axis_tuser[0] && (cnt_after == CW'(2));
      scan_k    <= AW'(1);
      found     <= 1'b0;
    end else if (state == plem_pkg::ST_SCAN) begin
      scan_k <= scan_k + AW'(1);
    end
    // Scan: remember the first and the last y that differ from the start.
    if (scan_v && (rd_y != y0)) begin
      if (!found) begin
        found   <= 1'b1;
        first_y <= rd_y;
      end
      diff_y <= rd_y;
    end
    if (state == plem_pkg::ST_INIT) begin
      idx      <= AW'(1);
      cur_x    <= x0;
      cur_y    <= y0;
      pend_max <= 1'b0;
      pend_min <= 1'b0;
      pend_os  <= path_open;
      if (path_open) begin
        up       <= up_open;
        up0      <= up_open;
        pend_min <= up_open;
        pend_max <= !up_open;
      end else begin
        up  <= up_closed;
        up0 <= up_closed;
        if (!found) begin
          noflag <= 1'b1;
        end
      end
    end else if (state == plem_pkg::ST_PROC && out_free) begin
      if (step_max) begin
        up <= 1'b0;
      end else if (step_min) begin
        up <= 1'b1;
      end
      cur_x    <= rd_x;
      cur_y    <= rd_y;
      pend_max <= 1'b0;
      pend_min <= 1'b0;
      pend_os  <= 1'b0;
      idx      <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_v <= 1'b0;
    end else begin
      scan_v <= (state == plem_pkg::ST_SCAN);
    end
  end

  // Output register and minima numbering; numbers go out in vertex order.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      min_cnt <= '0;
    end else if ((state == plem_pkg::ST_PROC || state == plem_pkg::ST_LAST) && out_free) begin
      o_valid <= 1'b1;
      o_x     <= cur_x;
      o_y     <= cur_y;
      o_ovf   <= ovf;
      o_os    <= pend_os;
      if (state == plem_pkg::ST_PROC) begin
        o_idx  <= 6'(idx - AW'(1));
        o_max  <= pend_max || step_max;
        o_min  <= pend_min || step_min;
        o_oe   <= 1'b0;
        o_last <= 1'b0;
        o_num  <= (pend_min || step_min) ? min_cnt : '0;
        o_kind <= (pend_min || step_min) && path_kind;
        if ((pend_min || step_min) && (min_cnt != 16'hFFFF)) begin
          min_cnt <= min_cnt + 16'd1;
        end
      end else begin
        o_idx  <= 6'(last_idx);
        o_max  <= pend_max || end_max;
        o_min  <= pend_min || end_min;
        o_oe   <= path_open;
        o_last <= 1'b1;
        o_num  <= (pend_min || end_min) ? min_cnt : '0;
        o_kind <= (pend_min || end_min) && path_kind;
        if ((pend_min || end_min) && (min_cnt != 16'hFFFF)) begin
          min_cnt <= min_cnt + 16'd1;
        end
      end
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tlast  = o_last;
  assign m_axis_tuser  = o_kind;
  assign m_axis_tdata  = {5'd0, o_ovf, o_num, o_oe, o_os, o_max, o_min, o_y, o_x, o_idx};

endmodule
`default_nettype wire
